// ----- src/ihq_pkg.sv -----
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int ID_COUNT     = 64;
    localparam int ID_W         = 6;
    localparam int CNT_W        = 7;
    localparam int IN_KEY_W     = 32;
    localparam int OUT_KEY_W    = 32;
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_QUEUED = 3'd2,
        ST_FULL       = 3'd3,
        ST_DUPLICATE  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_WAIT,
        S_UP_FINAL,
        S_RM_WAIT,
        S_LIFT_WAIT,
        S_POP,
        S_POP_LAST,
        S_DN_WAIT,
        S_DN_FINAL,
        S_DONE
    } t_state;

endpackage

// ----- src/ihq_level.sv -----
// ----------------------------------------------------------------------------
// ihq_level
// One heap level: sibling pairs kept in an even and an odd bank, one write
// and one registered pair read per cycle.
// ----------------------------------------------------------------------------
module ihq_level
    import ihq_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int LEVEL    = 0,
    parameter int NODE_W   = 7
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [NODE_W-1:0]   i_rd_node,
    input  logic                i_wr_en,
    input  logic [NODE_W-1:0]   i_wr_node,
    input  logic [KEY_BITS-1:0] i_wr_key,
    input  logic [ID_W-1:0]     i_wr_id,
    output logic [KEY_BITS-1:0] o_even_key,
    output logic [ID_W-1:0]     o_even_id,
    output logic [KEY_BITS-1:0] o_odd_key,
    output logic [ID_W-1:0]     o_odd_id
);

    localparam int DEPTH = (LEVEL < 2) ? 1 : (1 << (LEVEL - 1));

    logic [KEY_BITS-1:0] r_mem_ek [DEPTH];
    logic [ID_W-1:0]     r_mem_ei [DEPTH];
    logic [KEY_BITS-1:0] r_mem_ok [DEPTH];
    logic [ID_W-1:0]     r_mem_oi [DEPTH];

    generate
        if (DEPTH == 1) begin : g_single
            always_ff @(posedge i_clk) begin
                if (i_wr_en) begin
                    if (i_wr_node[0]) begin
                        r_mem_ok[0] <= i_wr_key;
                        r_mem_oi[0] <= i_wr_id;
                    end else begin
                        r_mem_ek[0] <= i_wr_key;
                        r_mem_ei[0] <= i_wr_id;
                    end
                end
                if (i_rd_en) begin
                    o_even_key <= r_mem_ek[0];
                    o_even_id  <= r_mem_ei[0];
                    o_odd_key  <= r_mem_ok[0];
                    o_odd_id   <= r_mem_oi[0];
                end
            end
        end else begin : g_multi
            logic [LEVEL-2:0] w_wi;
            logic [LEVEL-2:0] w_ri;
            assign w_wi = i_wr_node[LEVEL-1:1];
            assign w_ri = i_rd_node[LEVEL-1:1];

            always_ff @(posedge i_clk) begin
                if (i_wr_en) begin
                    if (i_wr_node[0]) begin
                        r_mem_ok[w_wi] <= i_wr_key;
                        r_mem_oi[w_wi] <= i_wr_id;
                    end else begin
                        r_mem_ek[w_wi] <= i_wr_key;
                        r_mem_ei[w_wi] <= i_wr_id;
                    end
                end
                if (i_rd_en) begin
                    o_even_key <= r_mem_ek[w_ri];
                    o_even_id  <= r_mem_ei[w_ri];
                    o_odd_key  <= r_mem_ok[w_ri];
                    o_odd_id   <= r_mem_oi[w_ri];
                end
            end
        end
    endgenerate

endmodule

// ----- src/ihq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihq_ctrl
// Operation sequencer: walks sift-up, lift and sift-down level by level,
// keeps the id-to-node map, queued flags, count and the result register.
// ----------------------------------------------------------------------------
module ihq_ctrl
    import ihq_pkg::*;
#(
    parameter  int CAPACITY = DEF_CAPACITY,
    parameter  int KEY_BITS = DEF_KEY_BITS,
    localparam int NW       = $clog2(CAPACITY + 1),
    localparam int LW       = $clog2(NW)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [ID_W-1:0]      i_pid,
    input  logic [IN_KEY_W-1:0]  i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [ID_W-1:0]      o_out_id,
    output logic [OUT_KEY_W-1:0] o_out_key,
    output logic [OUT_KEY_W-1:0] o_min_key,
    output logic [CNT_W-1:0]     o_total,
    output logic                 o_rd_en,
    output logic [LW-1:0]        o_rd_lvl,
    output logic [NW-1:0]        o_rd_node,
    input  logic [KEY_BITS-1:0]  i_rd_even_key,
    input  logic [ID_W-1:0]      i_rd_even_id,
    input  logic [KEY_BITS-1:0]  i_rd_odd_key,
    input  logic [ID_W-1:0]      i_rd_odd_id,
    output logic                 o_put_en,
    output logic [LW-1:0]        o_put_lvl,
    output logic [NW-1:0]        o_put_node,
    output logic [KEY_BITS-1:0]  o_put_key,
    output logic [ID_W-1:0]      o_put_id
);

    function automatic logic [LW-1:0] msb_lvl(input logic [NW-1:0] n);
        logic [LW-1:0] l;
        l = '0;
        for (int i = 0; i < NW; i++) begin
            if (n[i]) l = LW'(i);
        end
        return l;
    endfunction

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_pid, n_pid;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [NW-1:0]       r_node, n_node;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic                r_sel_odd, n_sel_odd;
    logic [KEY_BITS-1:0] r_mk, n_mk;
    logic [ID_W-1:0]     r_mid, n_mid;
    logic [KEY_BITS-1:0] r_gkey, n_gkey;
    logic [ID_W-1:0]     r_gid, n_gid;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ID_COUNT-1:0] r_queued, n_queued;
    logic [KEY_BITS-1:0] r_root_key, n_root_key;
    logic                r_ovalid, n_ovalid;
    logic                w_load;

    logic [NW-1:0]       r_map [ID_COUNT];
    logic [NW-1:0]       r_map_node;

    logic [2:0]           r_o_status;
    logic [ID_W-1:0]      r_o_id;
    logic [OUT_KEY_W-1:0] r_o_key;
    logic [OUT_KEY_W-1:0] r_o_min;
    logic [CNT_W-1:0]     r_o_total;

    logic [NW-1:0]       w_cnt_n;
    logic [NW-1:0]       w_ins_node;
    logic [NW-1:0]       w_up_node;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [ID_W-1:0]     w_rd_id;
    logic [NW:0]         w_twice;
    logic                w_right_ok;
    logic                w_take_r;
    logic [KEY_BITS-1:0] w_ck;
    logic [ID_W-1:0]     w_cid;
    logic [NW-1:0]       w_dn_node;
    logic [NW:0]         w_dn_twice;

    assign w_cnt_n    = NW'(r_count);
    assign w_ins_node = w_cnt_n + NW'(1);
    assign w_up_node  = r_node >> 1;
    assign w_rd_key   = r_sel_odd ? i_rd_odd_key : i_rd_even_key;
    assign w_rd_id    = r_sel_odd ? i_rd_odd_id : i_rd_even_id;
    assign w_twice    = {r_node, 1'b0};
    assign w_right_ok = w_twice < {1'b0, w_cnt_n};
    assign w_take_r   = w_right_ok && (i_rd_odd_key < i_rd_even_key);
    assign w_ck       = w_take_r ? i_rd_odd_key : i_rd_even_key;
    assign w_cid      = w_take_r ? i_rd_odd_id : i_rd_even_id;
    assign w_dn_node  = NW'({r_node, w_take_r});
    assign w_dn_twice = {w_dn_node, 1'b0};

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_status   = r_status;
        n_pid      = r_pid;
        n_key      = r_key;
        n_node     = r_node;
        n_lvl      = r_lvl;
        n_sel_odd  = r_sel_odd;
        n_mk       = r_mk;
        n_mid      = r_mid;
        n_gkey     = r_gkey;
        n_gid      = r_gid;
        n_count    = r_count;
        n_queued   = r_queued;
        w_load     = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_lvl   = r_lvl;
        o_rd_node  = r_node;
        o_put_en   = 1'b0;
        o_put_lvl  = r_lvl;
        o_put_node = r_node;
        o_put_key  = w_rd_key;
        o_put_id   = w_rd_id;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_pid   = i_pid;
                    n_key   = KEY_BITS'(i_key);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_gid    = '0;
                n_gkey   = '0;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_queued[r_pid]) begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_DONE;
                        end else if (w_cnt_n >= NW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_node = w_ins_node;
                            n_lvl  = msb_lvl(w_ins_node);
                            if (w_ins_node == NW'(1)) begin
                                n_state = S_UP_FINAL;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_lvl  = msb_lvl(w_ins_node) - LW'(1);
                                o_rd_node = w_ins_node >> 1;
                                n_sel_odd = w_ins_node[1];
                                n_state   = S_UP_WAIT;
                            end
                        end
                    end
                    OP_EXTRACT: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_lvl  = '0;
                            o_rd_node = NW'(1);
                            n_node    = NW'(1);
                            n_lvl     = '0;
                            n_sel_odd = 1'b1;
                            n_state   = S_RM_WAIT;
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_queued[r_pid] || (r_map_node > w_cnt_n)) begin
                            n_status = ST_NOT_QUEUED;
                            n_state  = S_DONE;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_lvl  = msb_lvl(r_map_node);
                            o_rd_node = r_map_node;
                            n_node    = r_map_node;
                            n_lvl     = msb_lvl(r_map_node);
                            n_sel_odd = r_map_node[0];
                            n_state   = S_RM_WAIT;
                        end
                    end
                    OP_NOP: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_UP_WAIT: begin
                if (w_rd_key > r_key) begin
                    o_put_en = 1'b1;
                    n_node   = w_up_node;
                    n_lvl    = r_lvl - LW'(1);
                    if (w_up_node == NW'(1)) begin
                        n_state = S_UP_FINAL;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_lvl  = r_lvl - LW'(2);
                        o_rd_node = w_up_node >> 1;
                        n_sel_odd = w_up_node[1];
                    end
                end else begin
                    n_state = S_UP_FINAL;
                end
            end
            S_UP_FINAL: begin
                o_put_en        = 1'b1;
                o_put_key       = r_key;
                o_put_id        = r_pid;
                n_queued[r_pid] = 1'b1;
                n_count         = r_count + CNT_W'(1);
                n_gid           = r_pid;
                n_gkey          = r_key;
                n_state         = S_DONE;
            end
            S_RM_WAIT: begin
                n_gkey = w_rd_key;
                n_gid  = w_rd_id;
                if (r_node == NW'(1)) begin
                    n_state = S_POP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_lvl  = r_lvl - LW'(1);
                    o_rd_node = w_up_node;
                    n_sel_odd = r_node[1];
                    n_state   = S_LIFT_WAIT;
                end
            end
            S_LIFT_WAIT: begin
                o_put_en = 1'b1;
                n_node   = w_up_node;
                n_lvl    = r_lvl - LW'(1);
                if (w_up_node == NW'(1)) begin
                    n_state = S_POP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_lvl  = r_lvl - LW'(2);
                    o_rd_node = w_up_node >> 1;
                    n_sel_odd = w_up_node[1];
                end
            end
            S_POP: begin
                n_queued[r_gid] = 1'b0;
                n_count         = r_count - CNT_W'(1);
                n_node          = NW'(1);
                n_lvl           = '0;
                if (r_count == CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_lvl  = msb_lvl(w_cnt_n);
                    o_rd_node = w_cnt_n;
                    n_sel_odd = w_cnt_n[0];
                    n_state   = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_mk  = w_rd_key;
                n_mid = w_rd_id;
                if (w_twice > {1'b0, w_cnt_n}) begin
                    n_state = S_DN_FINAL;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_lvl  = r_lvl + LW'(1);
                    o_rd_node = NW'(w_twice);
                    n_state   = S_DN_WAIT;
                end
            end
            S_DN_WAIT: begin
                if (w_ck < r_mk) begin
                    o_put_en  = 1'b1;
                    o_put_key = w_ck;
                    o_put_id  = w_cid;
                    n_node    = w_dn_node;
                    n_lvl     = r_lvl + LW'(1);
                    if (w_dn_twice > {1'b0, w_cnt_n}) begin
                        n_state = S_DN_FINAL;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_lvl  = r_lvl + LW'(2);
                        o_rd_node = NW'(w_dn_twice);
                    end
                end else begin
                    n_state = S_DN_FINAL;
                end
            end
            S_DN_FINAL: begin
                o_put_en  = 1'b1;
                o_put_key = r_mk;
                o_put_id  = r_mid;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_root_key = r_root_key;
        if (o_put_en && (o_put_node == NW'(1))) n_root_key = o_put_key;
        n_ovalid = r_ovalid;
        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_queued <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_queued <= n_queued;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_pid      <= n_pid;
        r_key      <= n_key;
        r_node     <= n_node;
        r_lvl      <= n_lvl;
        r_sel_odd  <= n_sel_odd;
        r_mk       <= n_mk;
        r_mid      <= n_mid;
        r_gkey     <= n_gkey;
        r_gid      <= n_gid;
        r_root_key <= n_root_key;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_id     <= r_gid;
            r_o_key    <= OUT_KEY_W'(r_gkey);
            r_o_min    <= (r_count != '0) ? OUT_KEY_W'(r_root_key) : '0;
            r_o_total  <= r_count;
        end
    end

    // id to heap node map
    always_ff @(posedge i_clk) begin
        if (o_put_en) r_map[o_put_id] <= o_put_node;
        if (i_in_valid && o_in_ready) r_map_node <= r_map[i_pid];
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_o_status;
    assign o_out_id    = r_o_id;
    assign o_out_key   = r_o_key;
    assign o_min_key   = r_o_min;
    assign o_total     = r_o_total;

endmodule

// ----- src/indexed_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of process entries with remove by process id.
//
// Input channel (s_axis): tuser carries the opcode (insert, extract minimum,
// remove process), tdata the process id and key. Output channel (m_axis):
// one item per input item; tuser carries the status, tdata the id and key
// of the affected entry, the new minimum key and the entry count.
// The heap is a row of level cells, one per tree level, each holding its
// sibling pairs; a sequencer walks one level per cycle.
// Insert, extract and remove take one registered level read per step of
// sift-up, lift and sift-down; errors and no-ops read no level.
// One item is in work at a time; the next is taken once the sequencer is
// back at idle, while a finished item may still wait in the output register.
// Reset (synchronous, active low) empties the heap and the id flags.
// A stalled receiver holds the result; the block then finishes the next
// item and waits until the output register is free.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue
    import ihq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // process_id[5:0], key[37:6], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // out_id[5:0], out_key[37:6],
                                          // min_key[69:38], entry_total[76:70], pad
    output logic [2:0]  o_m_axis_tuser    // status[2:0]
);

    localparam int NW = $clog2(CAPACITY + 1);
    localparam int NL = NW;
    localparam int LW = $clog2(NL);

    logic                 w_rd_en;
    logic [LW-1:0]        w_rd_lvl;
    logic [NW-1:0]        w_rd_node;
    logic                 w_put_en;
    logic [LW-1:0]        w_put_lvl;
    logic [NW-1:0]        w_put_node;
    logic [KEY_BITS-1:0]  w_put_key;
    logic [ID_W-1:0]      w_put_id;
    logic [KEY_BITS-1:0]  w_ek, w_ok;
    logic [ID_W-1:0]      w_ei, w_oi;
    logic [LW-1:0]        r_rd_lvl;
    logic [ID_W-1:0]      w_out_id;
    logic [OUT_KEY_W-1:0] w_out_key;
    logic [OUT_KEY_W-1:0] w_min_key;
    logic [CNT_W-1:0]     w_total;

    logic [KEY_BITS-1:0]  lv_ek [NL];
    logic [ID_W-1:0]      lv_ei [NL];
    logic [KEY_BITS-1:0]  lv_ok [NL];
    logic [ID_W-1:0]      lv_oi [NL];

    generate
        for (genvar g = 0; g < NL; g++) begin : g_level
            ihq_level #(
                .KEY_BITS (KEY_BITS),
                .LEVEL    (g),
                .NODE_W   (NW)
            ) u_level (
                .i_clk      (i_clk),
                .i_rd_en    (w_rd_en && (w_rd_lvl == LW'(g))),
                .i_rd_node  (w_rd_node),
                .i_wr_en    (w_put_en && (w_put_lvl == LW'(g))),
                .i_wr_node  (w_put_node),
                .i_wr_key   (w_put_key),
                .i_wr_id    (w_put_id),
                .o_even_key (lv_ek[g]),
                .o_even_id  (lv_ei[g]),
                .o_odd_key  (lv_ok[g]),
                .o_odd_id   (lv_oi[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rd_lvl <= w_rd_lvl;
    end

    always_comb begin
        w_ek = '0;
        w_ei = '0;
        w_ok = '0;
        w_oi = '0;
        for (int g = 0; g < NL; g++) begin
            if (r_rd_lvl == LW'(g)) begin
                w_ek = lv_ek[g];
                w_ei = lv_ei[g];
                w_ok = lv_ok[g];
                w_oi = lv_oi[g];
            end
        end
    end

    ihq_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_pid         (i_s_axis_tdata[5:0]),
        .i_key         (i_s_axis_tdata[37:6]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (o_m_axis_tuser),
        .o_out_id      (w_out_id),
        .o_out_key     (w_out_key),
        .o_min_key     (w_min_key),
        .o_total       (w_total),
        .o_rd_en       (w_rd_en),
        .o_rd_lvl      (w_rd_lvl),
        .o_rd_node     (w_rd_node),
        .i_rd_even_key (w_ek),
        .i_rd_even_id  (w_ei),
        .i_rd_odd_key  (w_ok),
        .i_rd_odd_id   (w_oi),
        .o_put_en      (w_put_en),
        .o_put_lvl     (w_put_lvl),
        .o_put_node    (w_put_node),
        .o_put_key     (w_put_key),
        .o_put_id      (w_put_id)
    );

    assign o_m_axis_tdata = {3'b000, w_total, w_min_key, w_out_key, w_out_id};

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_put_en && w_rd_en) |-> ((w_put_lvl != w_rd_lvl) || (w_put_node != w_rd_node)))
        else $error("heap node read and written in the same cycle");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY))
            |-> ((w_total == '0) && (w_min_key == '0) && (w_out_id == '0)))
        else $error("empty status with a non-empty heap");
`endif

endmodule

// ----- tb/sv/ihq_checker.sv -----
// ----------------------------------------------------------------------------
// ihq_checker
// Watches both item channels of the indexed min-heap queue, predicts every
// result from a private copy of the heap and its id map, and compares the
// results field by field, oldest first.
// ----------------------------------------------------------------------------
module ihq_checker
    import ihq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_tvalid,
    input  logic                i_in_tready,
    input  logic [39:0]         i_in_tdata,    // process_id, key, pad
    input  logic [1:0]          i_in_tuser,    // opcode
    input  logic                i_out_tvalid,
    input  logic                i_out_tready,
    input  logic [79:0]         i_out_tdata,   // out_id, out_key, min_key, entry_total, pad
    input  logic [2:0]          i_out_tuser,   // status
    output int                  o_mismatch_count,
    output int                  o_pending,
    output int                  o_held,
    output logic [ID_COUNT-1:0] o_queued
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]           status;
        logic [ID_W-1:0]      id;
        logic [OUT_KEY_W-1:0] key;
        logic [OUT_KEY_W-1:0] min_key;
        logic [CNT_W-1:0]     total;
    } t_heap_reply;

    logic [OUT_KEY_W-1:0] slot_key [DEF_CAPACITY];
    logic [ID_W-1:0]      slot_pid [DEF_CAPACITY];
    logic [ID_COUNT-1:0]  pid_queued;
    int                   pid_slot [ID_COUNT];
    int                   held;
    int                   mismatches;
    t_heap_reply          awaited_replies[$];

    task automatic place(input int s, input logic [OUT_KEY_W-1:0] k,
                         input logic [ID_W-1:0] pid);
        slot_key[s]   = k;
        slot_pid[s]   = pid;
        pid_slot[pid] = s;
    endtask

    // pops the root and sifts the last entry down, left child on ties
    task automatic pop_min(output logic [ID_W-1:0] pid, output logic [OUT_KEY_W-1:0] k);
        int                   n;
        int                   i;
        int                   l;
        int                   c;
        logic [OUT_KEY_W-1:0] mk;
        logic [ID_W-1:0]      mid;
        pid = slot_pid[0];
        k   = slot_key[0];
        pid_queued[pid] = 1'b0;
        held = held - 1;
        n = held;
        if (n == 0) return;
        mk  = slot_key[n];
        mid = slot_pid[n];
        i   = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= n) break;
            c = l;
            if (l + 1 < n && slot_key[l + 1] < slot_key[l]) c = l + 1;
            if (slot_key[c] < mk) begin
                place(i, slot_key[c], slot_pid[c]);
                i = c;
            end else begin
                break;
            end
        end
        place(i, mk, mid);
    endtask

    task automatic heap_apply(input t_op op, input logic [ID_W-1:0] pid,
                              input logic [OUT_KEY_W-1:0] k, output t_heap_reply r);
        int                   i;
        int                   p;
        logic [OUT_KEY_W-1:0] ek;
        logic [ID_W-1:0]      gid;
        logic [OUT_KEY_W-1:0] gkey;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (pid_queued[pid]) begin
                    r.status = ST_DUPLICATE;
                end else if (held >= DEF_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    i = held;
                    while (i > 0) begin
                        p = (i - 1) / 2;
                        if (slot_key[p] > k) begin
                            place(i, slot_key[p], slot_pid[p]);
                            i = p;
                        end else begin
                            break;
                        end
                    end
                    place(i, k, pid);
                    pid_queued[pid] = 1'b1;
                    held = held + 1;
                    r.id  = pid;
                    r.key = k;
                end
            end
            OP_EXTRACT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pop_min(gid, gkey);
                    r.id  = gid;
                    r.key = gkey;
                end
            end
            OP_REMOVE: begin
                if (!pid_queued[pid] || pid_slot[pid] >= held) begin
                    r.status = ST_NOT_QUEUED;
                end else begin
                    // lift the entry to the root regardless of keys, then pop it
                    i  = pid_slot[pid];
                    ek = slot_key[i];
                    while (i > 0) begin
                        p = (i - 1) / 2;
                        place(i, slot_key[p], slot_pid[p]);
                        i = p;
                    end
                    place(0, ek, pid);
                    pop_min(gid, gkey);
                    r.id  = gid;
                    r.key = gkey;
                end
            end
            default: ;
        endcase
        r.min_key = (held != 0) ? slot_key[0] : '0;
        r.total   = held[CNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [OUT_KEY_W-1:0] want,
                               input logic [OUT_KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_heap_reply want;
        t_heap_reply got;
        if (!i_rst_n) begin
            held       = 0;
            pid_queued = '0;
            awaited_replies.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got = {i_out_tuser, i_out_tdata[5:0], i_out_tdata[37:6],
                       i_out_tdata[69:38], i_out_tdata[76:70]};
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                    mismatches = mismatches + 1;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", OUT_KEY_W'(want.status), OUT_KEY_W'(got.status));
                    check_field("out_id", OUT_KEY_W'(want.id), OUT_KEY_W'(got.id));
                    check_field("out_key", want.key, got.key);
                    check_field("min_key", want.min_key, got.min_key);
                    check_field("entry_total", OUT_KEY_W'(want.total),
                                OUT_KEY_W'(got.total));
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                heap_apply(t_op'(i_in_tuser), i_in_tdata[5:0], i_in_tdata[37:6], want);
                awaited_replies.push_back(want);
            end
        end
        o_mismatch_count <= mismatches;
        o_pending        <= awaited_replies.size();
        o_held           <= held;
        o_queued         <= pid_queued;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the indexed min-heap queue. A directed opening
// hits empty, duplicate, not-queued and no-op cases and key extremes; random
// phases then fill the heap to full, drain it by extract and remove, and mix
// all operations, with random gaps and output stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
    import ihq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [39:0]         in_data  = '0;   // process_id[5:0], key[37:6], pad
    logic [1:0]          in_user  = '0;   // opcode
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [79:0]         out_data;        // out_id, out_key, min_key, entry_total, pad
    logic [2:0]          out_user;        // status
    int                  chk_mismatches;
    int                  chk_pending;
    int                  chk_held;
    logic [ID_COUNT-1:0] chk_queued;

    int unsigned cycle_count = 0;
    int          items_sent  = 0;
    int          op_count [4];
    int          full_hits   = 0;
    logic        calm;

    indexed_min_heap_queue u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    ihq_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_tvalid      (in_valid),
        .i_in_tready      (in_ready),
        .i_in_tdata       (in_data),
        .i_in_tuser       (in_user),
        .i_out_tvalid     (out_valid),
        .i_out_tready     (out_ready),
        .i_out_tdata      (out_data),
        .i_out_tuser      (out_user),
        .o_mismatch_count (chk_mismatches),
        .o_pending        (chk_pending),
        .o_held           (chk_held),
        .o_queued         (chk_queued)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // no idling on either side inside this window
    assign calm = (cycle_count >= 4000) && (cycle_count < 9000);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, chk_pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    task automatic send_item(input t_op op, input logic [ID_W-1:0] pid,
                             input logic [31:0] key);
        in_valid <= 1'b1;
        in_user  <= op;
        in_data  <= {2'b00, key, pid};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        op_count[op] = op_count[op] + 1;
        items_sent   = items_sent + 1;
        if (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // first id at or after a random start whose queued flag matches
    function automatic logic [ID_W-1:0] pick_pid(input logic want_queued);
        int start;
        int j;
        start = $urandom_range(0, ID_COUNT - 1);
        for (j = 0; j < ID_COUNT; j++) begin
            if (chk_queued[(start + j) % ID_COUNT] == want_queued)
                return ID_W'((start + j) % ID_COUNT);
        end
        return ID_W'(start);
    endfunction

    initial begin
        int phase_no;
        int kind;
        int len;
        int guard;
        int r;
        int first_random;
        foreach (op_count[j]) op_count[j] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_item(OP_EXTRACT, 6'd0,  32'h0);
        send_item(OP_REMOVE,  6'd0,  32'h0);
        send_item(OP_NOP,     6'd63, 32'hFFFF_FFFF);
        send_item(OP_INSERT,  6'd0,  32'hFFFF_FFFF);
        send_item(OP_INSERT,  6'd63, 32'h0000_0000);
        send_item(OP_INSERT,  6'd63, 32'h0000_0005);
        send_item(OP_INSERT,  6'd21, 32'h0000_0000);
        send_item(OP_INSERT,  6'd42, 32'h8000_0000);
        send_item(OP_INSERT,  6'd7,  32'h0000_0000);
        send_item(OP_REMOVE,  6'd42, 32'h0);
        send_item(OP_REMOVE,  6'd0,  32'h0);
        send_item(OP_REMOVE,  6'd42, 32'h0);
        send_item(OP_NOP,     6'd0,  32'h0);
        send_item(OP_EXTRACT, 6'd63, 32'hFFFF_FFFF);
        send_item(OP_EXTRACT, 6'd0,  32'h0);
        send_item(OP_EXTRACT, 6'd0,  32'h0);
        send_item(OP_EXTRACT, 6'd0,  32'h0);
        send_item(OP_INSERT,  6'd1,  32'hAAAA_AAAA);
        send_item(OP_INSERT,  6'd2,  32'h5555_5555);
        send_item(OP_REMOVE,  6'd2,  32'h0);
        send_item(OP_REMOVE,  6'd1,  32'h0);
        wait_empty();

        first_random = items_sent;
        phase_no = 0;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            if (phase_no % 5 == 4) wait_empty();
            kind  = $urandom_range(0, 3);
            len   = $urandom_range(20, 80);
            guard = 0;
            case (kind)
                0: begin
                    while (chk_held < DEF_CAPACITY && guard < 120) begin
                        if ($urandom_range(0, 9) == 0)
                            send_item(OP_INSERT, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      pick_key());
                        else
                            send_item(OP_INSERT, pick_pid(1'b0), pick_key());
                        guard++;
                    end
                    if (chk_held == DEF_CAPACITY) full_hits++;
                    repeat (3) send_item(OP_INSERT, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                         pick_key());
                end
                1: begin
                    while (chk_held > 0 && guard < 120) begin
                        r = $urandom_range(0, 99);
                        if (r < 50)
                            send_item(OP_EXTRACT, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      $urandom);
                        else if (r < 95)
                            send_item(OP_REMOVE, pick_pid(1'b1), $urandom);
                        else
                            send_item(OP_REMOVE, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      $urandom);
                        guard++;
                    end
                    send_item(OP_EXTRACT, ID_W'($urandom_range(0, ID_COUNT - 1)), $urandom);
                    send_item(OP_REMOVE, ID_W'($urandom_range(0, ID_COUNT - 1)), $urandom);
                end
                default: begin
                    repeat (len) begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            send_item(OP_INSERT, ($urandom_range(0, 4) != 0) ?
                                      pick_pid(1'b0) : ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      pick_key());
                        else if (r < 65)
                            send_item(OP_EXTRACT, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      $urandom);
                        else if (r < 92)
                            send_item(OP_REMOVE, ($urandom_range(0, 4) != 0) ?
                                      pick_pid(1'b1) : ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      $urandom);
                        else
                            send_item(OP_NOP, ID_W'($urandom_range(0, ID_COUNT - 1)),
                                      $urandom);
                    end
                end
            endcase
            phase_no++;
        end

        wait_empty();
        repeat (50) @(posedge clk);
        $display("Covered %0d items: %0d insert, %0d extract, %0d remove, %0d no-op",
                 items_sent, op_count[OP_INSERT], op_count[OP_EXTRACT],
                 op_count[OP_REMOVE], op_count[OP_NOP]);
        $display("Heap filled to capacity %0d times over %0d random phases",
                 full_hits, phase_no);
        if (chk_mismatches == 0 && chk_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
